[src/distinct_k_permutation_enumerator_top_defines.svh]
// Assertion macros shared by the enumerator modules.
`ifndef DISTINCT_K_PERMUTATION_ENUMERATOR_TOP_DEFINES_SVH
`define DISTINCT_K_PERMUTATION_ENUMERATOR_TOP_DEFINES_SVH
// Implication checked every clock, quiet during reset.
`define DKP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define DKP_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[src/dkpe_pkg.sv]
// Package: constants and command/status types of the enumerator.
package dkpe_pkg;
  localparam int MaxItemsDef  = 8;
  localparam int ValueBitsDef = 16;
  localparam int ElemBits     = 16;
  localparam int MBits        = 4;
  localparam int OpBits       = 2;
  localparam logic [OpBits-1:0] OP_CLEAR = 2'd0;
  localparam logic [OpBits-1:0] OP_LOAD  = 2'd1;
  localparam logic [OpBits-1:0] OP_NEXT  = 2'd2;

  typedef struct packed {
    logic clear;     // empty store
    logic restart;   // drop enumeration progress
    logic ins_start; // begin sorted insert
    logic ins_step;  // shift one entry / compare
    logic fill_init; // start first fill from depth 0
    logic adv_init;  // start advance from top depth
    logic walk;      // one step of fill/advance walk
    logic emit_init; // start emitting the chosen sequence
    logic emit_step; // move to next emitted element
  } dkpe_cmd_t;

  typedef struct packed {
    logic ins_done;
    logic walk_done;
    logic walk_ok;
    logic emit_last;
    logic startable;  // m in range and not finished
    logic started;
  } dkpe_sts_t;
endpackage

[src/dkpe_stream_if.sv]
// Valid/ready channel interfaces for the enumerator.
interface dkpe_in_if #(parameter int OpW = 2, parameter int ValW = 16) (input logic clk);
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  op;
  logic [ValW-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface dkpe_out_if #(parameter int ElW = 16) (input logic clk);
  logic           valid;
  logic           ready;
  logic [ElW-1:0] element;
  logic           last;
  logic           exhausted;
  modport source (output valid, element, last, exhausted, input ready);
  modport sink   (input valid, element, last, exhausted, output ready);
endinterface

[src/dkpe_datapath.sv]
// Datapath: sorted store, chosen positions, used mask and the backtracking walk.
module dkpe_datapath
  import dkpe_pkg::*;
#(
  parameter int MaxItems  = MaxItemsDef,
  parameter int ValueBits = ValueBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dkpe_cmd_t            cmd,
  input  logic [ValueBits-1:0] in_value,
  input  logic [MBits-1:0]     m_count,
  input  logic                 set_finished,
  output dkpe_sts_t            sts,
  output logic [ElemBits-1:0]  element
);
  localparam int PB = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int CB = $clog2(MaxItems + 1);
  localparam int DB = (CB > MBits) ? CB : MBits;

  logic [ValueBits-1:0] vals [MaxItems];
  logic [PB-1:0]        chosen [MaxItems];
  logic [CB-1:0]        item_count;
  logic [MaxItems-1:0]  used_mask;
  logic                 started, finished;

  // insert: pos walks down from item_count
  logic [CB-1:0] ins_pos;
  logic [ValueBits-1:0] ins_val;
  // walk: depth, candidate q, mode (0 fill, 1 advance search)
  logic [DB-1:0] depth;
  logic [CB-1:0] q;
  logic          mode_adv, walk_done, walk_ok;
  logic [DB-1:0] emit_k;

  logic [DB-1:0] m_ext;
  assign m_ext = DB'(m_count);

  // drop the load when the store is full
  logic ins_full;
  assign ins_full = (item_count >= CB'(MaxItems));

  logic ins_done;
  assign ins_done = ins_full || (ins_pos == '0) ||
                    !(vals[PB'(ins_pos - CB'(1))] > ins_val);

  logic [PB-1:0] cur_p;
  assign cur_p = chosen[PB'(depth)];
  logic q_in, q_free, q_dup;
  assign q_in   = (q < item_count);
  assign q_free = q_in && !used_mask[PB'(q)];
  assign q_dup  = q_in && (vals[PB'(q)] == vals[cur_p]);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      used_mask  <= '0;
      started    <= 1'b0;
      finished   <= 1'b0;
      walk_done  <= 1'b0;
      walk_ok    <= 1'b0;
    end else begin
      if (cmd.clear) item_count <= '0;
      if (cmd.restart) begin
        used_mask <= '0;
        started   <= 1'b0;
        finished  <= 1'b0;
      end
      if (set_finished) finished <= 1'b1;
      if (cmd.ins_start) begin
        ins_pos <= item_count;
        ins_val <= in_value;
      end
      if (cmd.ins_step && !ins_full) begin
        if (ins_done) begin
          vals[PB'(ins_pos)] <= ins_val;
          item_count <= item_count + CB'(1);
        end else begin
          vals[PB'(ins_pos)] <= vals[PB'(ins_pos - CB'(1))];
          ins_pos <= ins_pos - CB'(1);
        end
      end
      if (cmd.fill_init) begin
        used_mask <= '0;
        depth     <= '0;
        q         <= '0;
        mode_adv  <= 1'b0;
        started   <= 1'b1;
        walk_done <= 1'b0;
        walk_ok   <= 1'b0;
      end
      if (cmd.adv_init) begin
        depth     <= m_ext - DB'(1);
        q         <= CB'(chosen[PB'(m_ext - DB'(1))]) + CB'(1);
        used_mask[chosen[PB'(m_ext - DB'(1))]] <= 1'b0;
        mode_adv  <= 1'b1;
        walk_done <= 1'b0;
        walk_ok   <= 1'b0;
      end
      if (cmd.walk) begin
        if (!mode_adv) begin
          // fill depth with lowest free position
          if (depth == m_ext) begin
            walk_done <= 1'b1;
            walk_ok   <= 1'b1;
          end else if (q_free) begin
            chosen[PB'(depth)] <= PB'(q);
            used_mask[PB'(q)]  <= 1'b1;
            depth <= depth + DB'(1);
            q     <= '0;
          end else begin
            q <= q + CB'(1);
          end
        end else begin
          if (!q_in) begin
            // back up one level
            if (depth == '0) begin
              walk_done <= 1'b1;
            end else begin
              depth <= depth - DB'(1);
              q     <= CB'(chosen[PB'(depth - DB'(1))]) + CB'(1);
              used_mask[chosen[PB'(depth - DB'(1))]] <= 1'b0;
            end
          end else if (q_dup || !q_free) begin
            q <= q + CB'(1);
          end else begin
            chosen[PB'(depth)] <= PB'(q);
            used_mask[PB'(q)]  <= 1'b1;
            depth    <= depth + DB'(1);
            q        <= '0;
            mode_adv <= 1'b0;
          end
        end
      end
      if (cmd.emit_init) emit_k <= '0;
      if (cmd.emit_step) emit_k <= emit_k + DB'(1);
    end
  end

  assign element = ElemBits'(vals[chosen[PB'(emit_k)]]);
  assign sts.ins_done  = ins_done;
  assign sts.walk_done = walk_done;
  assign sts.walk_ok   = walk_ok;
  assign sts.emit_last = (emit_k + DB'(1) == m_ext);
  assign sts.started   = started;
  assign sts.startable = !finished && (m_count != '0) &&
                         (DB'(m_count) <= DB'(item_count)) &&
                         (DB'(m_count) <= DB'(MaxItems));

`include "distinct_k_permutation_enumerator_top_defines.svh"
  `DKP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, item_count <= CB'(MaxItems))
  `DKP_ASSERT_NXT(a_clear_empty, clk, rst, cmd.clear, item_count == '0)
  `DKP_ASSERT_NXT(a_fill_starts, clk, rst, cmd.fill_init, started)
endmodule

[src/dkpe_ctrl.sv]
// Controller: sequences insert, fill/advance walk and output run per request.
module dkpe_ctrl
  import dkpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OpBits-1:0] in_op,
  input  logic              cfg_we,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output logic              out_exh,
  output dkpe_cmd_t         cmd,
  output logic              set_finished,
  input  dkpe_sts_t         sts
);
  typedef enum logic [2:0] {S_IDLE, S_INS, S_WALK, S_EMIT, S_EXH} state_t;
  state_t state;
  logic   acc;
  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    set_finished = 1'b0;
    cmd.restart = cfg_we;
    case (state)
      S_IDLE: if (acc) begin
        case (in_op)
          OP_CLEAR: begin cmd.clear = 1'b1; cmd.restart = 1'b1; end
          OP_LOAD:  begin cmd.ins_start = 1'b1; cmd.restart = 1'b1; end
          OP_NEXT: begin
            if (!sts.startable) set_finished = 1'b1;
            else if (!sts.started) cmd.fill_init = 1'b1;
            else cmd.adv_init = 1'b1;
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (!sts.walk_done) cmd.walk = 1'b1;
        else if (sts.walk_ok) cmd.emit_init = 1'b1;
        else set_finished = 1'b1;
      end
      S_INS:  cmd.ins_step = 1'b1;
      S_EMIT: if (out_ready && !sts.emit_last) cmd.emit_step = 1'b1;
      default: ;
    endcase
  end

  assign out_valid = (state == S_EMIT) || (state == S_EXH);
  assign out_exh   = (state == S_EXH);
  assign out_last  = (state == S_EMIT) && sts.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (acc) begin
          case (in_op)
            OP_LOAD: state <= S_INS;
            OP_NEXT: state <= sts.startable ? S_WALK : S_EXH;
            default: state <= S_IDLE;
          endcase
        end
        S_INS:  if (sts.ins_done) state <= S_IDLE;
        S_WALK: if (sts.walk_done) state <= sts.walk_ok ? S_EMIT : S_EXH;
        S_EMIT: if (out_ready && sts.emit_last) state <= S_IDLE;
        S_EXH:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`include "distinct_k_permutation_enumerator_top_defines.svh"
  `DKP_ASSERT_IMP(a_exh_not_last, clk, rst, out_valid && out_exh, !out_last)
  `DKP_ASSERT_IMP(a_busy_not_ready, clk, rst, out_valid, !in_ready)
  `DKP_ASSERT_NXT(a_emit_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

[src/distinct_k_permutation_enumerator_top.sv]
// Enumerator of distinct k-permutations of a loaded multiset.
// Input channel "in" (op, value): op 0 clears the store, op 1 inserts value
// into the sorted store, op 2 requests the next sequence. Output channel
// "out" returns m_count elements per request, last set on the final one, or
// a single exhausted result (element 0) when no sequence is left.
// A load's sorted insert shifts one entry a cycle. A next request walks the
// backtracking stack one candidate position a cycle, then returns one element
// a cycle while the receiver accepts. The block takes one item at a time;
// in_ready is low while it works or while results wait. A stalled receiver
// holds the current element stable.
// cfg_we/cfg_data write m_count and restart the enumeration; write it only
// when idle. Synchronous reset empties the store, sets m_count to 1 and
// clears all progress; no clearing pass is needed.
module distinct_k_permutation_enumerator_top
  import dkpe_pkg::*;
#(
  parameter int MaxItems  = MaxItemsDef,
  parameter int ValueBits = ValueBitsDef
) (
  input  logic             clk,
  input  logic             rst,
  dkpe_in_if.sink          in,
  dkpe_out_if.source       out,
  input  logic             cfg_we,
  input  logic [MBits-1:0] cfg_data
);
  logic [MBits-1:0] m_count;
  dkpe_cmd_t cmd;
  dkpe_sts_t sts;
  logic      set_finished;

  always_ff @(posedge clk) begin
    if (rst) m_count <= MBits'(1);
    else if (cfg_we) m_count <= cfg_data;
  end

  dkpe_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready), .in_op(in.op),
    .cfg_we,
    .out_valid(out.valid), .out_ready(out.ready),
    .out_last(out.last), .out_exh(out.exhausted),
    .cmd, .set_finished, .sts
  );

  logic [ElemBits-1:0] element;
  dkpe_datapath #(.MaxItems(MaxItems), .ValueBits(ValueBits)) u_dp (
    .clk, .rst, .cmd,
    .in_value(ValueBits'(in.value)),
    .m_count, .set_finished, .sts, .element
  );
  assign out.element = out.exhausted ? '0 : element;
endmodule

[dv/dkpe_checker.sv]
// Checker: watches the enumerator channels, predicts the sequences and compares them.
module dkpe_checker
  import dkpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  dkpe_in_if               in_ch,
  dkpe_out_if              out_ch,
  input  logic             cfg_we,
  input  logic [MBits-1:0] cfg_data,
  output int               fails,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = MaxItemsDef;

  typedef struct packed {
    logic [ElemBits-1:0] element;
    logic                last;
    logic                exhausted;
  } seq_beat_t;

  seq_beat_t        beat_q[$];
  logic [15:0]      store_vals[Slots];
  int unsigned      store_cnt;
  int unsigned      pick[Slots];
  logic [Slots-1:0] taken;
  logic             begun;
  logic             done_all;
  logic [MBits-1:0] seq_len;
  int               fail_cnt;

  function automatic void fill_depths(int unsigned from, int unsigned m);
    for (int unsigned d = from; d < m; d++) begin
      for (int unsigned p = 0; p < store_cnt; p++) begin
        if (!taken[p]) begin
          pick[d] = p;
          taken[p] = 1'b1;
          break;
        end
      end
    end
  endfunction

  // Backtrack from the deepest depth, skipping equal neighbors.
  function automatic bit step_sequence(int unsigned m);
    int unsigned d;
    int unsigned p;
    d = m;
    while (d > 0) begin
      d--;
      p = pick[d];
      taken[p] = 1'b0;
      for (int unsigned q = p + 1; q < store_cnt; q++) begin
        if (store_vals[q] == store_vals[p]) continue;
        if (taken[q]) continue;
        pick[d] = q;
        taken[q] = 1'b1;
        fill_depths(d + 1, m);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void insert_sorted(logic [15:0] v);
    int unsigned slot;
    if (store_cnt >= Slots) return;
    slot = store_cnt;
    while (slot > 0 && store_vals[slot-1] > v) slot--;
    for (int unsigned k = store_cnt; k > slot; k--) store_vals[k] = store_vals[k-1];
    store_vals[slot] = v;
    store_cnt++;
  endfunction

  function automatic void predict_request();
    int unsigned m;
    bit ok;
    seq_beat_t b;
    m = seq_len;
    ok = 1'b0;
    if (!done_all && m >= 1 && m <= store_cnt && m <= Slots) begin
      if (!begun) begin
        taken = '0;
        fill_depths(0, m);
        begun = 1'b1;
        ok = 1'b1;
      end else begin
        ok = step_sequence(m);
      end
    end
    if (!ok) begin
      done_all = 1'b1;
      b = '{element: '0, last: 1'b0, exhausted: 1'b1};
      beat_q.insert(beat_q.size(), b);
    end else begin
      for (int unsigned k = 0; k < m; k++) begin
        b = '{element: store_vals[pick[k]], last: (k + 1 == m), exhausted: 1'b0};
        beat_q.insert(beat_q.size(), b);
      end
    end
  endfunction

  always @(posedge clk) begin
    seq_beat_t want;
    if (rst) begin
      beat_q.delete();
      store_cnt = 0;
      taken = '0;
      begun = 1'b0;
      done_all = 1'b0;
      seq_len = 4'd1;
      fail_cnt = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (beat_q.size() == 0) begin
          $error("unexpected result transfer: element=%0h", out_ch.element);
          fail_cnt++;
        end else begin
          want = beat_q.pop_front();
          if (out_ch.element !== want.element) begin
            $error("element: expected %0h, got %0h", want.element, out_ch.element);
            fail_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_cnt++;
          end
          if (out_ch.exhausted !== want.exhausted) begin
            $error("exhausted: expected %0b, got %0b", want.exhausted, out_ch.exhausted);
            fail_cnt++;
          end
        end
      end
      if (cfg_we) begin
        seq_len = cfg_data;
        taken = '0;
        begun = 1'b0;
        done_all = 1'b0;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          OP_CLEAR: begin
            store_cnt = 0;
            taken = '0;
            begun = 1'b0;
            done_all = 1'b0;
          end
          OP_LOAD: begin
            insert_sorted(in_ch.value);
            taken = '0;
            begun = 1'b0;
            done_all = 1'b0;
          end
          OP_NEXT: predict_request();
          default: ;
        endcase
      end
    end
    fails <= fail_cnt;
    pending <= beat_q.size();
  end
endmodule

[dv/testbench.sv]
// Testbench top: clock, reset, stimulus for the enumerator and the verdict.
module testbench;
  import dkpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpBits-1:0] OP_NOP = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [MBits-1:0] cfg_data = '0;
  int               fails;
  int               pending;
  int               sent = 0;
  logic             hold_rx = 1'b0;
  event             hold_go;

  dkpe_in_if  #(.OpW(OpBits), .ValW(ValueBitsDef)) in_if (clk);
  dkpe_out_if #(.ElW(ElemBits)) out_if (clk);

  distinct_k_permutation_enumerator_top DUT (
    .clk(clk), .rst(rst), .in(in_if.sink), .out(out_if.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  dkpe_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_CLEAR;
    in_if.value = '0;
    out_if.ready = 1'b0;
  end

  // Hold off the receiver once triggered, then release it.
  initial begin
    @(hold_go);
    hold_rx <= 1'b1;
    repeat (300) @(negedge clk);
    hold_rx <= 1'b0;
  end

  // Receiver: one long hold-off, one stretch always ready, random otherwise.
  always @(negedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else if (hold_rx) out_if.ready <= 1'b0;
    else if (sent >= 100 && sent < 150) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 99) >= 25);
  end

  task automatic send(input logic [OpBits-1:0] o, input logic [15:0] v);
    @(negedge clk);
    while (!(sent >= 100 && sent < 150) && $urandom_range(0, 99) < 25) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= o;
    in_if.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  // Drop valid, wait out all results and any load still in progress.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_len(input logic [MBits-1:0] m);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_load;
    int n_req;
    logic [15:0] base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(OP_NOP, 16'hffff);
    send(OP_NEXT, 16'h1234);
    send(OP_LOAD, 16'hffff);
    send(OP_LOAD, 16'h0000);
    send(OP_LOAD, 16'h0000);
    repeat (4) send(OP_NEXT, 16'h0);
    write_len(4'd3);
    repeat (4) send(OP_NEXT, 16'h0);
    write_len(4'd0);
    send(OP_NEXT, 16'h0);
    write_len(4'd15);
    send(OP_NEXT, 16'h0);
    send(OP_CLEAR, 16'h0);
    send(OP_NEXT, 16'h0);
    for (int i = 0; i < 9; i++) send(OP_LOAD, 16'(9 - i) ^ 16'haaa0);
    write_len(4'd8);
    // Stall the receiver so the second request waits at the input.
    -> hold_go;
    repeat (2) send(OP_NEXT, 16'h0);

    while (sent < 210) begin
      case ($urandom_range(0, 9))
        0: write_len(4'd8);
        1: write_len(4'($urandom_range(0, 15)));
        default: write_len(4'($urandom_range(1, 4)));
      endcase
      send(OP_CLEAR, 16'($urandom));
      n_load = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
      base = 16'($urandom);
      for (int i = 0; i < n_load; i++) begin
        if ($urandom_range(0, 3) == 0) send(OP_LOAD, 16'($urandom));
        else send(OP_LOAD, base + 16'($urandom_range(0, 2)));
      end
      n_req = $urandom_range(3, 12);
      for (int i = 0; i < n_req; i++) begin
        case ($urandom_range(0, 19))
          0: send(OP_NOP, 16'($urandom));
          1: send(OP_LOAD, base + 16'($urandom_range(0, 2)));
          default: send(OP_NEXT, 16'($urandom));
        endcase
      end
    end

    settle();
    repeat (30) @(negedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
